>>> hw/rtl/mfp_pkg.sv
// ============================================================================
// mfp_pkg
// Shared types and constants for the forward Mojette projection block.
// ============================================================================
`default_nettype none

package mfp_pkg;

    localparam int MAX_WIDTH      = 64;
    localparam int MAX_HEIGHT     = 64;
    localparam int DEF_MAX_DIRS   = 8;
    localparam int DEF_BIN_DEPTH  = 2048;

    localparam int COL_W   = 6;
    localparam int ROW_W   = 7;
    localparam int SUM_W   = 18;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = 12;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BEYOND = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DIRS   = 3'd2;
    localparam logic [2:0] REG_SLOPE  = 3'd3;
    localparam logic [2:0] REG_STEP   = 3'd4;

    typedef struct packed {
        logic start;
        logic calc;
        logic rd;
        logic wr;
        logic clr;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic clr_last;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/mojette_forward_projection_top.sv
// ============================================================================
// mojette_forward_projection_top
// Forward Mojette projection engine: one 64-bit bin bank per direction.
// ============================================================================
// Channel   Handshake            Payload
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
// s         s_valid/s_ready      s_op, s_pixel_value, s_proj_index, s_bin_index
// m         m_valid/m_ready      m_bin_value, m_bin_count, m_status, m_frame_complete
//
// A pixel transfer passes through decode, address, bank read, bank write and result.
// A bin read passes through the same steps except the bank write.
// A clear zeroes every bank, one bank row zeroed per cycle.
// After reset a clearing pass over all BIN_DEPTH bank rows runs before s_ready rises.
// A new transfer is taken while the previous result still waits on m_ready.
// ============================================================================
`default_nettype none

module mojette_forward_projection_top
    import mfp_pkg::*;
#(
    parameter int MAX_DIRS  = DEF_MAX_DIRS,
    parameter int BIN_DEPTH = DEF_BIN_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_op,
    input  wire logic [DATA_W-1:0] s_pixel_value,
    input  wire logic [2:0]        s_proj_index,
    input  wire logic [10:0]       s_bin_index,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_bin_value,
    output logic [CNT_W-1:0]       m_bin_count,
    output logic [1:0]             m_status,
    output logic                   m_frame_complete
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mfp_datapath #(
        .MAX_DIRS  (MAX_DIRS),
        .BIN_DEPTH (BIN_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_op             (s_op),
        .s_pixel_value    (s_pixel_value),
        .s_proj_index     (s_proj_index),
        .s_bin_index      (s_bin_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_bin_value      (m_bin_value),
        .m_bin_count      (m_bin_count),
        .m_status         (m_status),
        .m_frame_complete (m_frame_complete),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

`default_nettype wire

>>> hw/rtl/mfp_ctrl.sv
// ============================================================================
// mfp_ctrl
// Sequencer for the projection datapath: clearing pass, bin update and read.
// ============================================================================
`default_nettype none

module mfp_ctrl
    import mfp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CALC  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                cmd.calc = 1'b1;
                case (stat.op)
                    OP_CLEAR: state_next = S_CLEAR;
                    OP_PIXEL: state_next = S_READ;
                    OP_READ:  state_next = S_READ;
                    default:  state_next = S_DONE;
                endcase
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = (stat.op == OP_PIXEL) ? S_WRITE : S_DONE;
            end
            S_WRITE: begin
                cmd.wr     = 1'b1;
                state_next = S_DONE;
            end
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("State register is not one-hot.");
    a_clear_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR && !stat.clr_last) |=> (state_reg == S_CLEAR))
        else $error("Clearing pass left early.");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.out_busy)
        else $error("Result loaded over an untaken result.");

endmodule

`default_nettype wire

>>> hw/rtl/mfp_datapath.sv
// ============================================================================
// mfp_datapath
// Configuration registers, raster position, bin banks and result register.
// ============================================================================
`default_nettype none

module mfp_datapath
    import mfp_pkg::*;
#(
    parameter int MAX_DIRS  = DEF_MAX_DIRS,
    parameter int BIN_DEPTH = DEF_BIN_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic [1:0]        s_op,
    input  wire logic [DATA_W-1:0] s_pixel_value,
    input  wire logic [2:0]        s_proj_index,
    input  wire logic [10:0]       s_bin_index,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_bin_value,
    output logic [CNT_W-1:0]       m_bin_count,
    output logic [1:0]             m_status,
    output logic                   m_frame_complete,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat
);

    localparam int AW    = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
    localparam int DIR_W = $clog2(MAX_DIRS + 1);

    logic [6:0]        grid_width_reg, grid_height_reg;
    logic [3:0]        num_dirs_reg;
    logic [31:0]       slope_reg, step_reg;
    op_t               op_reg;
    logic [DATA_W-1:0] pix_reg;
    logic [2:0]        pi_reg;
    logic [10:0]       bi_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [1:0]        status_reg;
    logic              rok_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_bin_value_reg;
    logic [CNT_W-1:0]  m_bin_count_reg;
    logic [1:0]        m_status_reg;
    logic              m_frame_reg;

    logic [6:0]        eff_w, eff_h, wm1, hm1;
    logic [DIR_W-1:0]  nd;
    logic              in_frame, pi_active, clr_last;
    logic [DATA_W-1:0] rd_data [MAX_DIRS];
    logic [DATA_W-1:0] rd_sel;
    logic signed [3:0] pp;
    logic [3:0]        pq, pap;
    logic [CNT_W-1:0]  pcount;

    always_comb begin
        eff_w = (grid_width_reg == 7'd0) ? 7'd1 :
                (grid_width_reg > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : grid_width_reg;
        eff_h = (grid_height_reg == 7'd0) ? 7'd1 :
                (grid_height_reg > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : grid_height_reg;
        wm1 = eff_w - 7'd1;
        hm1 = eff_h - 7'd1;
        nd  = (8'(num_dirs_reg) > 8'(MAX_DIRS)) ? DIR_W'(MAX_DIRS) : DIR_W'(num_dirs_reg);
        in_frame  = (row_reg < eff_h);
        pi_active = (8'(pi_reg) < 8'(nd));
        pp     = slope_reg[{pi_reg, 2'b00} +: 4];
        pq     = (step_reg[{pi_reg, 2'b00} +: 4] == 4'd0) ? 4'd1 : step_reg[{pi_reg, 2'b00} +: 4];
        pap    = pp[3] ? 4'(-pp) : 4'(pp);
        pcount = CNT_W'(wm1) * CNT_W'(pap) + CNT_W'(hm1) * CNT_W'(pq) + CNT_W'(1);
        clr_last = (32'(clr_cnt_reg) == BIN_DEPTH - 1);
        rd_sel = '0;
        for (int i = 0; i < MAX_DIRS; i++) begin
            if (32'(pi_reg) == i) begin
                rd_sel = rd_data[i];
            end
        end
    end

    for (genvar i = 0; i < MAX_DIRS; i++) begin : g_bank
        logic signed [3:0]       p;
        logic [3:0]              q, ap;
        logic signed [SUM_W-1:0] cp, rq, hq, wp, b;
        logic                    bok;
        logic [AW-1:0]           addr_reg;
        logic                    bok_reg;
        logic [DATA_W-1:0]       rd_data_reg;
        logic [DATA_W-1:0]       mem [BIN_DEPTH];

        always_comb begin
            p  = slope_reg[(i % 8) * 4 +: 4];
            q  = (step_reg[(i % 8) * 4 +: 4] == 4'd0) ? 4'd1 : step_reg[(i % 8) * 4 +: 4];
            ap = p[3] ? 4'(-p) : 4'(p);
            cp = $signed({{(SUM_W - COL_W){1'b0}}, col_reg}) * $signed({{(SUM_W - 4){p[3]}}, p});
            rq = $signed(SUM_W'(row_reg) * SUM_W'(q));
            hq = $signed(SUM_W'(hm1) * SUM_W'(q));
            wp = p[3] ? $signed(SUM_W'(wm1) * SUM_W'(ap)) : '0;
            b  = cp - rq + hq + wp;
            bok = (i < 32'(nd)) && !b[SUM_W-1] && (b < $signed(SUM_W'(BIN_DEPTH))) && in_frame;
        end

        always_ff @(posedge aclk) begin
            if (cmd.calc) begin
                addr_reg <= (op_reg == OP_READ) ? AW'(SUM_W'(bi_reg)) : AW'(b);
                bok_reg  <= bok;
            end
            if (cmd.clr) begin
                mem[clr_cnt_reg] <= '0;
            end else if (cmd.wr && bok_reg) begin
                mem[addr_reg] <= rd_data_reg + pix_reg;
            end
            if (cmd.rd) begin
                rd_data_reg <= mem[addr_reg];
            end
        end

        assign rd_data[i] = rd_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 7'd4;
            grid_height_reg <= 7'd4;
            num_dirs_reg    <= 4'd4;
            slope_reg       <= 32'h0000_21FE;
            step_reg        <= 32'h1111_1111;
            col_reg         <= '0;
            row_reg         <= '0;
            clr_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_WIDTH:  grid_width_reg  <= cfg_data[6:0];
                    REG_HEIGHT: grid_height_reg <= cfg_data[6:0];
                    REG_DIRS:   num_dirs_reg    <= cfg_data[3:0];
                    REG_SLOPE:  slope_reg       <= cfg_data;
                    REG_STEP:   step_reg        <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clr) begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + AW'(1);
                col_reg     <= '0;
                row_reg     <= '0;
            end else if (cmd.wr && in_frame) begin
                if (7'(col_reg) + 7'd1 >= eff_w) begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg     <= op_t'(s_op);
            pix_reg    <= s_pixel_value;
            pi_reg     <= s_proj_index;
            bi_reg     <= s_bin_index;
        end
        if (cmd.calc) begin
            count_reg  <= '0;
            status_reg <= ST_OK;
            rok_reg    <= 1'b0;
            if (op_reg == OP_PIXEL) begin
                status_reg <= in_frame ? ST_OK : ST_BEYOND;
            end else if (op_reg == OP_READ) begin
                if (!pi_active) begin
                    status_reg <= ST_RANGE;
                end else begin
                    count_reg <= pcount;
                    if ({1'b0, bi_reg} >= pcount || SUM_W'(bi_reg) >= SUM_W'(BIN_DEPTH)) begin
                        status_reg <= ST_RANGE;
                    end else begin
                        rok_reg <= 1'b1;
                    end
                end
            end
        end
        if (cmd.out_load) begin
            m_bin_value_reg <= rok_reg ? rd_sel : '0;
            m_bin_count_reg <= count_reg;
            m_status_reg    <= status_reg;
            m_frame_reg     <= !in_frame;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_bin_value      = m_bin_value_reg;
    assign m_bin_count      = m_bin_count_reg;
    assign m_status         = m_status_reg;
    assign m_frame_complete = m_frame_reg;

    assign stat.op       = op_reg;
    assign stat.clr_last = clr_last;
    assign stat.out_busy = m_valid_reg && !m_ready;

endmodule

`default_nettype wire
